@@ hdl/bple_pkg.sv @@
// Package with the shared types and constants of the boundary pixel label pair extractor.
`default_nettype none

package bple_pkg;

   localparam int LABEL_W     = 16;
   localparam int VALUE_W     = 16;
   localparam int COORD_W     = 12;
   localparam int DIM_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int NPAIR       = 4;
   localparam int WIDTH_LIMIT = 4096;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(1);

   // One boundary pixel with its candidate pairs, handed from the front end to the back end.
   typedef struct packed {
      logic [NPAIR-1:0][LABEL_W-1:0] lo;
      logic [NPAIR-1:0][LABEL_W-1:0] hi;
      logic [NPAIR-1:0]              keep;
      logic [COORD_W-1:0]            col;
      logic [COORD_W-1:0]            row;
      logic [VALUE_W-1:0]            value;
   } pix_entry_type;

   // One result transaction.
   typedef struct packed {
      logic [LABEL_W-1:0] label_lo;
      logic [LABEL_W-1:0] label_hi;
      logic [COORD_W-1:0] col_x;
      logic [COORD_W-1:0] row_y;
      logic [VALUE_W-1:0] value_out;
      logic               last_of_pixel;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hdl/bple_ram.sv @@
// Generic single-write, single-read RAM with registered, read-first output.
`default_nettype none

module bple_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [ADDR_W-1:0]      waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic                   re,
   input  wire logic [ADDR_W-1:0]      raddr,
   output logic      [WIDTH-1:0]       rdata
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/bple_fifo.sv @@
// Small synchronous register FIFO used between the pipeline parts and at the output.
`default_nettype none

module bple_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [WIDTH-1:0]     push_data,
   input  wire logic                 pop,
   output logic      [WIDTH-1:0]     pop_data,
   output logic                      empty,
   output logic                      full,
   output logic      [CNT_W-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/bple_front.sv @@
// Front end: position tracking, column stores, 3x3 window and pair classification.
`default_nettype none

module bple_front
   import bple_pkg::*;
#(
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [DIM_W-1:0]        csr_wdata,
   input  wire logic                    accept,
   input  wire logic                    kind,
   input  wire logic [LABEL_W-1:0]      pixel_label,
   input  wire logic                    boundary_mask,
   input  wire logic [VALUE_W-1:0]      boundary_value,
   output logic                         entry_push,
   output pix_entry_type                entry,
   output logic [1:0]                   busy
);

   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HC_W  = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;
   localparam int CX_W  = DIM_W + 1;

   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [1:0]       bank_ff, bank_in;

   logic [HC_W-1:0]  h_cmp;
   logic [ROW_W:0]   h_eff;
   logic [DIM_W-1:0] w_eff;
   logic [ROW_W:0]   row_next;

   // Center position, one row and one column behind the incoming item.
   logic                   y_pos;
   logic signed [CX_W-1:0] cx;
   logic signed [CX_W-1:0] w_s;
   logic [ROW_W-1:0]       cy;
   logic                   top_ok, lft_ok, mid_ok, rgt_ok;
   logic [LABEL_W-1:0]     lab_eff;
   logic                   msk_eff;
   logic [VALUE_W-1:0]     val_eff;

   logic [LABEL_W-1:0]       lab_rd [3];
   logic [VALUE_W:0]         ctr_rd;

   logic                   s1_valid_ff;
   logic [1:0]             s1_bank_ff;
   logic [LABEL_W-1:0]     s1_lab_ff;
   logic signed [CX_W-1:0] s1_cx_ff;
   logic [ROW_W-1:0]       s1_cy_ff;
   logic                   s1_top_ok_ff, s1_bot_ok_ff;
   logic                   s1_lft_ok_ff, s1_mid_ok_ff, s1_rgt_ok_ff;

   // Column slices of the two previous steps (left, middle, right).
   logic [2:0][LABEL_W-1:0] win1_ff, win2_ff;
   logic [2:0][LABEL_W-1:0] slice;
   logic [2:0][LABEL_W-1:0] top_m, mid_m, bot_m;
   logic                    hold_mask_ff;
   logic [VALUE_W-1:0]      hold_value_ff;
   logic                    boundary;

   logic                    s2_valid_ff;
   logic [2:0][LABEL_W-1:0] s2_top_ff, s2_bot_ff;
   logic [LABEL_W-1:0]      s2_ml_ff, s2_mr_ff;
   logic [COORD_W-1:0]      s2_col_ff, s2_row_ff;
   logic [VALUE_W-1:0]      s2_value_ff;

   logic [NPAIR-1:0][LABEL_W-1:0] pa, pb, plo, phi;
   logic [NPAIR-1:0]              keep;

   // Effective image size.
   always_comb begin
      h_cmp = HC_W'(height_ff);
      if (height_ff == '0) begin
         h_eff = (ROW_W + 1)'(1);
      end else if (h_cmp > HC_W'(MAX_HEIGHT)) begin
         h_eff = (ROW_W + 1)'(MAX_HEIGHT);
      end else begin
         h_eff = (ROW_W + 1)'(h_cmp);
      end
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(WIDTH_LIMIT)) begin
         w_eff = DIM_W'(WIDTH_LIMIT);
      end else begin
         w_eff = width_ff;
      end
   end

   assign lab_eff  = kind ? '0 : pixel_label;
   assign msk_eff  = kind ? 1'b0 : boundary_mask;
   assign val_eff  = kind ? '0 : boundary_value;
   assign row_next = {1'b0, row_ff} + (ROW_W + 1)'(1);

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      bank_in   = bank_ff;
      if (csr_write) begin
         if (csr_index == REG_IMAGE_HEIGHT || csr_index == REG_IMAGE_WIDTH) begin
            if (csr_index == REG_IMAGE_HEIGHT) begin
               height_in = csr_wdata;
            end else begin
               width_in = csr_wdata;
            end
            row_in  = '0;
            col_in  = '0;
            bank_in = '0;
         end
      end else if (accept) begin
         if (col_ff >= w_eff + DIM_W'(1)) begin
            row_in  = '0;
            col_in  = '0;
            bank_in = '0;
         end else if (row_next >= h_eff) begin
            row_in  = '0;
            col_in  = col_ff + DIM_W'(1);
            bank_in = (bank_ff == 2'd2) ? 2'd0 : bank_ff + 2'd1;
         end else begin
            row_in = row_next[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= DIM_RESET;
         width_ff  <= DIM_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         bank_ff   <= '0;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         bank_ff   <= bank_in;
      end
   end

   // Where the pixel being judged sits and which of its neighbours lie inside the image.
   always_comb begin
      y_pos  = (row_ff != '0);
      w_s    = $signed({1'b0, w_eff});
      cx     = $signed({1'b0, col_ff}) - (y_pos ? CX_W'(1) : CX_W'(2));
      cy     = y_pos ? row_ff - ROW_W'(1) : ROW_W'(h_eff - (ROW_W + 1)'(1));
      top_ok = y_pos ? (row_ff >= ROW_W'(2)) : (h_eff >= (ROW_W + 1)'(2));
      lft_ok = (cx >= CX_W'(1)) && (cx <= w_s);
      mid_ok = (cx >= CX_W'(0)) && (cx < w_s);
      rgt_ok = (cx >= -CX_W'(1)) && (cx < w_s - CX_W'(1));
   end

   for (genvar b = 0; b < 3; b++) begin : g_bank
      bple_ram #(
         .WIDTH(LABEL_W),
         .DEPTH(MAX_HEIGHT)
      ) u_bank (
         .clock(clock),
         .we   (accept && (bank_ff == 2'(b))),
         .waddr(row_ff),
         .wdata(lab_eff),
         .re   (accept),
         .raddr(row_ff),
         .rdata(lab_rd[b])
      );
   end

   bple_ram #(
      .WIDTH(VALUE_W + 1),
      .DEPTH(MAX_HEIGHT)
   ) u_center (
      .clock(clock),
      .we   (accept),
      .waddr(row_ff),
      .wdata({msk_eff, val_eff}),
      .re   (accept),
      .raddr(row_ff),
      .rdata(ctr_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bank_ff   <= bank_ff;
         s1_lab_ff    <= lab_eff;
         s1_cx_ff     <= cx;
         s1_cy_ff     <= cy;
         s1_top_ok_ff <= top_ok;
         s1_bot_ok_ff <= y_pos;
         s1_lft_ok_ff <= lft_ok;
         s1_mid_ok_ff <= mid_ok;
         s1_rgt_ok_ff <= rgt_ok;
      end
   end

   // Older columns sit two and one banks behind the one being written.
   always_comb begin
      unique case (s1_bank_ff)
         2'd0:    slice = {s1_lab_ff, lab_rd[2], lab_rd[1]};
         2'd1:    slice = {s1_lab_ff, lab_rd[0], lab_rd[2]};
         2'd2:    slice = {s1_lab_ff, lab_rd[1], lab_rd[0]};
         default: slice = '0;
      endcase
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic col_ok;
         col_ok   = (c == 0) ? s1_lft_ok_ff : ((c == 1) ? s1_mid_ok_ff : s1_rgt_ok_ff);
         top_m[c] = (col_ok && s1_top_ok_ff) ? win2_ff[c] : '0;
         mid_m[c] = col_ok ? win1_ff[c] : '0;
         bot_m[c] = (col_ok && s1_bot_ok_ff) ? slice[c] : '0;
      end
      boundary = s1_mid_ok_ff && hold_mask_ff && (mid_m[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mask_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            hold_mask_ff <= ctr_rd[VALUE_W];
         end
         s2_valid_ff <= s1_valid_ff && boundary;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win1_ff       <= slice;
         win2_ff       <= win1_ff;
         hold_value_ff <= ctr_rd[VALUE_W-1:0];
         s2_top_ff     <= top_m;
         s2_bot_ff     <= bot_m;
         s2_ml_ff      <= mid_m[0];
         s2_mr_ff      <= mid_m[2];
         s2_col_ff     <= s1_cx_ff[COORD_W-1:0];
         s2_row_ff     <= COORD_W'(s1_cy_ff);
         s2_value_ff   <= hold_value_ff;
      end
   end

   // Vertical, horizontal, diagonal and anti-diagonal pairs, ordered and deduplicated.
   always_comb begin
      pa[0] = s2_top_ff[1];
      pb[0] = s2_bot_ff[1];
      pa[1] = s2_ml_ff;
      pb[1] = s2_mr_ff;
      pa[2] = s2_top_ff[0];
      pb[2] = s2_bot_ff[2];
      pa[3] = s2_bot_ff[0];
      pb[3] = s2_top_ff[2];
      for (int k = 0; k < NPAIR; k++) begin
         plo[k] = (pa[k] < pb[k]) ? pa[k] : pb[k];
         phi[k] = (pa[k] < pb[k]) ? pb[k] : pa[k];
      end
      for (int k = 0; k < NPAIR; k++) begin
         keep[k] = (plo[k] != '0);
         for (int j = 0; j < k; j++) begin
            if (plo[j] == plo[k] && phi[j] == phi[k]) begin
               keep[k] = 1'b0;
            end
         end
      end
   end

   assign entry_push  = s2_valid_ff && (keep != '0);
   assign entry.lo    = plo;
   assign entry.hi    = phi;
   assign entry.keep  = keep;
   assign entry.col   = s2_col_ff;
   assign entry.row   = s2_row_ff;
   assign entry.value = s2_value_ff;
   assign busy        = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

endmodule

`default_nettype wire

@@ hdl/bple_back.sv @@
// Back end: expands one boundary pixel entry into its result transactions.
`default_nettype none

module bple_back
   import bple_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          entry_valid,
   input  pix_entry_type      entry,
   output logic               entry_pop,
   input  wire logic          rsp_full,
   output logic               rsp_push,
   output rsp_item_type       rsp_item
);

   logic [NPAIR-1:0] done_ff, done_in;
   logic [NPAIR-1:0] pending;
   logic [NPAIR-1:0] pick;
   logic             last;
   logic             fire;

   assign pending = entry.keep & ~done_ff;

   always_comb begin
      pick = '0;
      for (int k = NPAIR - 1; k >= 0; k--) begin
         if (pending[k]) begin
            pick = '0;
            pick[k] = 1'b1;
         end
      end
   end

   assign last = ((pending & ~pick) == '0);
   assign fire = entry_valid && !rsp_full;

   always_comb begin
      rsp_item.label_lo = '0;
      rsp_item.label_hi = '0;
      for (int k = 0; k < NPAIR; k++) begin
         if (pick[k]) begin
            rsp_item.label_lo = entry.lo[k];
            rsp_item.label_hi = entry.hi[k];
         end
      end
      rsp_item.col_x         = entry.col;
      rsp_item.row_y         = entry.row;
      rsp_item.value_out     = entry.value;
      rsp_item.last_of_pixel = last;
   end

   always_comb begin
      done_in = done_ff;
      if (fire) begin
         done_in = last ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign rsp_push  = fire;
   assign entry_pop = fire && last;

endmodule

`default_nettype wire

@@ hdl/boundary_pixel_label_pair_extractor_top.sv @@
// Top level of the boundary pixel label pair extractor.
`default_nettype none

// The block takes one label-image pixel per cycle while req_full is low,
// column by column with rows running fastest, and reports every adjacent
// segment label pair seen across a boundary pixel (label 0, mask 1) as one
// result transaction carrying the pair, the pixel position and its boundary
// value. A frame is image_width columns of image_height pixels followed by
// image_height + 1 pad transactions, which flush the last column. The front
// end reads three column banks and a per-row center store at the same row
// address in the cycle of acceptance and judges each pixel from a registered
// 3x3 window. Boundary pixels go through an eight-entry queue to the back end,
// which produces one result per cycle while the output queue is not full, so a
// pixel with four distinct pairs holds the back end for one result per pair.
// req_full rises when that queue, counting the pixels still in the front
// pipeline, could overflow; results wait in an eight-entry output queue. Stores
// need no clearing after reset. Writing either size register restarts the
// frame at column 0, row 0, and must only be done while the block is idle.
module boundary_pixel_label_pair_extractor_top
   import bple_pkg::*;
#(
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_kind,
   input  wire logic [LABEL_W-1:0]    req_pixel_label,
   input  wire logic                  req_boundary_mask,
   input  wire logic [VALUE_W-1:0]    req_boundary_value,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic      [LABEL_W-1:0]    rsp_label_lo,
   output logic      [LABEL_W-1:0]    rsp_label_hi,
   output logic      [COORD_W-1:0]    rsp_col_x,
   output logic      [COORD_W-1:0]    rsp_row_y,
   output logic      [VALUE_W-1:0]    rsp_value_out,
   output logic                       rsp_last_of_pixel,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DIM_W-1:0]      csr_wdata
);

   localparam int MQ_DEPTH  = 8;
   localparam int OQ_DEPTH  = 8;
   localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
   localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

   logic               accept;
   logic               entry_push;
   pix_entry_type      entry_in;
   pix_entry_type      entry_out;
   logic               mq_empty;
   logic               mq_full;
   logic [MQ_CNT_W-1:0] mq_count;
   logic               mq_pop;
   logic [1:0]         busy;
   logic               rsp_push;
   rsp_item_type       rsp_in;
   rsp_item_type       rsp_out;
   logic               oq_full;
   logic [OQ_CNT_W-1:0] oq_count;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // Every pixel still in the front pipeline may need one queue slot.
   assign req_full = ({1'b0, mq_count} + (MQ_CNT_W + 1)'(busy)) >= (MQ_CNT_W + 1)'(MQ_DEPTH);

   bple_front #(
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .kind          (req_kind),
      .pixel_label   (req_pixel_label),
      .boundary_mask (req_boundary_mask),
      .boundary_value(req_boundary_value),
      .entry_push    (entry_push),
      .entry         (entry_in),
      .busy          (busy)
   );

   bple_fifo #(
      .WIDTH($bits(pix_entry_type)),
      .DEPTH(MQ_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_push),
      .push_data(entry_in),
      .pop      (mq_pop),
      .pop_data (entry_out),
      .empty    (mq_empty),
      .full     (mq_full),
      .count    (mq_count)
   );

   bple_back u_back (
      .clock      (clock),
      .reset      (reset),
      .entry_valid(!mq_empty),
      .entry      (entry_out),
      .entry_pop  (mq_pop),
      .rsp_full   (oq_full || mq_full && 1'b0),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_in)
   );

   bple_fifo #(
      .WIDTH($bits(rsp_item_type)),
      .DEPTH(OQ_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_in),
      .pop      (rsp_pop),
      .pop_data (rsp_out),
      .empty    (rsp_empty),
      .full     (oq_full),
      .count    (oq_count)
   );

   assign rsp_label_lo      = rsp_out.label_lo;
   assign rsp_label_hi      = rsp_out.label_hi;
   assign rsp_col_x         = rsp_out.col_x;
   assign rsp_row_y         = rsp_out.row_y;
   assign rsp_value_out     = rsp_out.value_out;
   assign rsp_last_of_pixel = (oq_count != '0) && rsp_out.last_of_pixel;

endmodule

`default_nettype wire

@@ test/boundary_pixel_label_pair_extractor_top_tb.sv @@
// Self-checking testbench for the boundary pixel label pair extractor top level.
`default_nettype none

// The testbench streams label-image frames (pixels, then the pad
// transactions that flush the last column) through the request queue and
// checks every result against a behavioral predictor of the block.
//
// The driver and the monitor are clocked always blocks. The driver pulls
// pixels from a queue that the main initial block fills one phase at a time.
// On every accepted request transaction the predictor advances its own copy
// of the column stores and the frame position. It appends the label pairs
// that the pixel being judged produces to a queue of expected pairs. The
// monitor compares each popped result, field by field, with the oldest entry
// of that queue.
//
// Size registers are written only while the block is idle: after reset, and
// between phases once every expected pair has arrived and the front pipeline
// has had time to drain. Each phase starts with a register write. Every later
// read of a store entry therefore falls on an entry written earlier in the
// same frame, so broken frames and noise are safe.
//
// Both sides insert random gaps. Once in the run the receiver stops popping
// for a long stretch while the sender keeps pushing, so that both internal
// queues fill and req_full must throttle the input.
module boundary_pixel_label_pair_extractor_top_tb;
   import bple_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ROWS     = 4096;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 40;

   // Register indexes the block does not implement; a write to one must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   localparam bit KIND_PIXEL = 1'b0;
   localparam bit KIND_PAD   = 1'b1;

   typedef struct {
      bit        kind;
      bit [15:0] label;
      bit        mask;
      bit [15:0] value;
   } pixel_item_t;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic                 req_kind;
   logic [LABEL_W-1:0]   req_pixel_label;
   logic                 req_boundary_mask;
   logic [VALUE_W-1:0]   req_boundary_value;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [LABEL_W-1:0]   rsp_label_lo;
   logic [LABEL_W-1:0]   rsp_label_hi;
   logic [COORD_W-1:0]   rsp_col_x;
   logic [COORD_W-1:0]   rsp_row_y;
   logic [VALUE_W-1:0]   rsp_value_out;
   logic                 rsp_last_of_pixel;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   boundary_pixel_label_pair_extractor_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_kind           (req_kind),
      .req_pixel_label    (req_pixel_label),
      .req_boundary_mask  (req_boundary_mask),
      .req_boundary_value (req_boundary_value),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_label_lo       (rsp_label_lo),
      .rsp_label_hi       (rsp_label_hi),
      .rsp_col_x          (rsp_col_x),
      .rsp_row_y          (rsp_row_y),
      .rsp_value_out      (rsp_value_out),
      .rsp_last_of_pixel  (rsp_last_of_pixel),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Stimulus and expectation stores.
   pixel_item_t  pending_pixels[$];
   rsp_item_type expected_pairs[$];
   pixel_item_t  driven_pixel;
   int           error_count;
   int           random_items;
   int           pairs_seen;
   longint       cycle_count;

   // Predictor state: three label column banks, the per-row center store,
   // the hold register of the pixel being judged and the frame position.
   int unsigned label_bank[3][MAX_ROWS];
   int unsigned center_val[MAX_ROWS];
   int unsigned center_msk[MAX_ROWS];
   int unsigned held_val;
   int unsigned held_msk;
   int unsigned cur_row;
   int unsigned cur_col;
   int unsigned cur_bank;
   int unsigned height_reg;
   int unsigned width_reg;

   // Neighbor pairs in emission order: vertical, horizontal, diagonal, anti-diagonal.
   const int pair_offsets[4][4] = '{
      '{0, -1, 0, 1}, '{-1, 0, 1, 0}, '{-1, -1, 1, 1}, '{-1, 1, 1, -1}
   };

   function automatic int rows_in_use();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_ROWS) return MAX_ROWS;
      return height_reg;
   endfunction

   function automatic int cols_in_use();
      if (width_reg == 0) return 1;
      if (width_reg > WIDTH_LIMIT) return WIDTH_LIMIT;
      return width_reg;
   endfunction

   // Label at (col, row) as the block sees it when the pixel at (x, y) arrives.
   function automatic int unsigned label_at(int col, int row, int x, int y,
                                            int unsigned arriving, int h, int w);
      int back;
      if (col < 0 || col >= w || row < 0 || row >= h) return 0;
      if (col == x && row == y) return arriving;
      back = x - col;
      if (back < 0 || back > 3) return 0;
      return label_bank[(cur_bank + 6 - back) % 3][row % MAX_ROWS];
   endfunction

   // Advances the predictor by one accepted transaction and queues its pairs.
   function automatic void judge_pixel(pixel_item_t it);
      int           h, w, x, y, cx, cy, k, j, ridx;
      int unsigned  lab, msk, val, a, b, lo, hi;
      bit           dup;
      rsp_item_type found[$];
      rsp_item_type r;
      h    = rows_in_use();
      w    = cols_in_use();
      x    = cur_col;
      y    = cur_row;
      lab  = (it.kind == KIND_PAD) ? 0 : it.label;
      msk  = (it.kind == KIND_PAD) ? 0 : it.mask;
      val  = (it.kind == KIND_PAD) ? 0 : it.value;
      ridx = y % MAX_ROWS;
      if (y >= 1) begin
         cx = x - 1;
         cy = y - 1;
      end else begin
         cx = x - 2;
         cy = h - 1;
      end
      if (cx >= 0 && cx < w && held_msk == 1 && label_at(cx, cy, x, y, lab, h, w) == 0) begin
         for (k = 0; k < 4; k++) begin
            a = label_at(cx + pair_offsets[k][0], cy + pair_offsets[k][1], x, y, lab, h, w);
            b = label_at(cx + pair_offsets[k][2], cy + pair_offsets[k][3], x, y, lab, h, w);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (lo == 0) continue;
            dup = 0;
            for (j = 0; j < found.size(); j++)
               if (found[j].label_lo == lo && found[j].label_hi == hi) dup = 1;
            if (dup) continue;
            r.label_lo      = lo[LABEL_W-1:0];
            r.label_hi      = hi[LABEL_W-1:0];
            r.col_x         = cx[COORD_W-1:0];
            r.row_y         = cy[COORD_W-1:0];
            r.value_out     = held_val[VALUE_W-1:0];
            r.last_of_pixel = 1'b0;
            found.push_back(r);
         end
         if (found.size() > 0) found[found.size()-1].last_of_pixel = 1'b1;
         foreach (found[i]) expected_pairs.push_back(found[i]);
      end
      held_val = center_val[ridx];
      held_msk = center_msk[ridx];
      label_bank[cur_bank % 3][ridx] = lab;
      center_val[ridx] = val;
      center_msk[ridx] = msk;
      if (x >= w + 1) begin
         cur_row  = 0;
         cur_col  = 0;
         cur_bank = 0;
      end else begin
         cur_row++;
         if (cur_row >= h) begin
            cur_row = 0;
            cur_col++;
            cur_bank = (cur_bank + 1) % 3;
         end
      end
   endfunction

   function automatic int draw_gap();
      // Mostly back-to-back transactions, with an occasional random gap.
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 14);
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter guarding against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Request driver: predicts each accepted transaction, then offers the next
   // pending pixel after a random gap. A pushed item stays put while full is high.
   int driver_gap;
   always @(posedge clock) begin
      logic push_next;
      push_next = 1'b0;
      if (reset) begin
         driver_gap = 0;
      end else begin
         if (req_push && !req_full) judge_pixel(driven_pixel);
         if (req_push && req_full) begin
            push_next = 1'b1;
         end else if (driver_gap > 0) begin
            driver_gap--;
         end else if (pending_pixels.size() > 0) begin
            driven_pixel = pending_pixels.pop_front();
            req_kind           <= driven_pixel.kind;
            req_pixel_label    <= driven_pixel.label;
            req_boundary_mask  <= driven_pixel.mask;
            req_boundary_value <= driven_pixel.value;
            push_next  = 1'b1;
            driver_gap = draw_gap();
         end
      end
      req_push <= push_next;
   end

   // Result monitor: checks each popped pair and draws its own pop gaps. After
   // forty results it stops popping for a long stretch, once, so the block backs up.
   int  pop_gap;
   bit  long_hold_done;
   always @(posedge clock) begin
      logic         pop_next;
      rsp_item_type want;
      pop_next = 1'b0;
      if (reset) begin
         pop_gap        = 0;
         long_hold_done = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            pairs_seen++;
            if (expected_pairs.size() == 0) begin
               $display("%0t: unexpected result lo=%0d hi=%0d x=%0d y=%0d", $time,
                        rsp_label_lo, rsp_label_hi, rsp_col_x, rsp_row_y);
               error_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_label_lo !== want.label_lo) begin
                  $display("%0t: label_lo expected %0d actual %0d", $time,
                           want.label_lo, rsp_label_lo);
                  error_count++;
               end
               if (rsp_label_hi !== want.label_hi) begin
                  $display("%0t: label_hi expected %0d actual %0d", $time,
                           want.label_hi, rsp_label_hi);
                  error_count++;
               end
               if (rsp_col_x !== want.col_x) begin
                  $display("%0t: col_x expected %0d actual %0d", $time, want.col_x, rsp_col_x);
                  error_count++;
               end
               if (rsp_row_y !== want.row_y) begin
                  $display("%0t: row_y expected %0d actual %0d", $time, want.row_y, rsp_row_y);
                  error_count++;
               end
               if (rsp_value_out !== want.value_out) begin
                  $display("%0t: value_out expected %0h actual %0h", $time,
                           want.value_out, rsp_value_out);
                  error_count++;
               end
               if (rsp_last_of_pixel !== want.last_of_pixel) begin
                  $display("%0t: last_of_pixel expected %0b actual %0b", $time,
                           want.last_of_pixel, rsp_last_of_pixel);
                  error_count++;
               end
            end
            if (pairs_seen == 40 && !long_hold_done) begin
               long_hold_done = 1;
               pop_gap = 600;
            end else begin
               pop_gap = draw_gap();
            end
         end
         if (pop_gap > 0) pop_gap--;
         else pop_next = 1'b1;
      end
      rsp_pop <= pop_next;
   end

   // Writes one register through the configuration channel and mirrors size writes.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_index <= idx;
      csr_wdata <= data[DIM_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_IMAGE_HEIGHT) height_reg = data % 8192;
      else if (idx == REG_IMAGE_WIDTH) width_reg = data % 8192;
      else return;
      cur_row  = 0;
      cur_col  = 0;
      cur_bank = 0;
   endtask

   // Waits until every pushed pixel has been accepted and every pair has come
   // back, then lets the front pipeline settle before the next register write.
   task automatic wait_idle();
      do @(posedge clock); while (pending_pixels.size() > 0 || req_push ||
                                  expected_pairs.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(input bit kind, input int unsigned label, input bit mask,
                            input int unsigned value);
      pixel_item_t it;
      it.kind  = kind;
      it.label = label[15:0];
      it.mask  = mask;
      it.value = value[15:0];
      pending_pixels.push_back(it);
   endtask

   function automatic int unsigned pick_label();
      case ($urandom_range(0, 7))
         0, 1, 2: return 0;
         3:       return 65535;
         4:       return $urandom_range(0, 65535);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   // Queues one random frame of h by w pixels and its pad transactions. A
   // nonzero cut stops the frame after that many transactions. Some pads are
   // replaced by pixels beyond the image or carry garbage fields.
   task automatic add_random_frame(input int h, input int w, input int cut);
      int total, n;
      total = 0;
      for (n = 0; n < w * h + h + 1; n++) begin
         if (cut != 0 && total >= cut) break;
         if (n < w * h)
            add_pixel(KIND_PIXEL, pick_label(), $urandom_range(0, 1), $urandom_range(0, 65535));
         else if ($urandom_range(0, 3) == 0)
            add_pixel($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 1),
                      $urandom_range(0, 65535));
         else
            add_pixel(KIND_PAD, 0, 0, 0);
         total++;
      end
      random_items += total;
   endtask

   // Queues a 3x3 frame from a column-major label list, boundary mask on every
   // zero label, followed by its pads.
   task automatic add_fixed_frame(input int unsigned labels[9], input int unsigned value);
      for (int i = 0; i < 9; i++) add_pixel(KIND_PIXEL, labels[i], labels[i] == 0, value);
      for (int i = 0; i < 4; i++) add_pixel(KIND_PAD, 0, 0, 0);
   endtask

   initial begin
      int h, w;
      error_count        = 0;
      random_items       = 0;
      pairs_seen         = 0;
      cycle_count        = 0;
      req_push           = 1'b0;
      req_kind           = 1'b0;
      req_pixel_label    = '0;
      req_boundary_mask  = 1'b0;
      req_boundary_value = '0;
      rsp_pop            = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = REG_IMAGE_HEIGHT;
      csr_wdata          = '0;
      held_val           = 0;
      held_msk           = 0;
      cur_row            = 0;
      cur_col            = 0;
      cur_bank           = 0;
      height_reg         = DIM_RESET;
      width_reg          = DIM_RESET;
      reset              = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a center boundary pixel with four distinct pairs, all
      // neighbors equal (one pair with lo equal to hi after duplicates drop),
      // and a diagonal of zeros where corner pixels see only the image edge.
      write_reg(REG_IMAGE_HEIGHT, 3);
      write_reg(REG_IMAGE_WIDTH, 3);
      add_fixed_frame('{1, 2, 3, 4, 0, 5, 6, 7, 8}, 16'hFFFF);
      add_fixed_frame('{9, 9, 9, 9, 0, 9, 9, 9, 9}, 0);
      add_fixed_frame('{0, 65535, 1, 65535, 0, 65535, 1, 65535, 0}, 16'h5AA5);
      wait_idle();

      // Unimplemented indexes must not restart the frame.
      write_reg(REG_SPARE_A, 5);
      write_reg(REG_SPARE_B, 8191);
      add_fixed_frame('{3, 0, 7, 0, 0, 0, 7, 0, 3}, 16'h0001);
      wait_idle();

      // Size extremes, including zero and values past the supported range.
      write_reg(REG_IMAGE_HEIGHT, 0);
      write_reg(REG_IMAGE_WIDTH, 0);
      add_random_frame(1, 1, 0);
      add_random_frame(1, 1, 0);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, 8191);
      write_reg(REG_IMAGE_WIDTH, 1);
      add_random_frame(MAX_ROWS, 1, 0);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, 1);
      write_reg(REG_IMAGE_WIDTH, 8191);
      add_random_frame(1, WIDTH_LIMIT, 0);
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, MAX_ROWS);
      write_reg(REG_IMAGE_WIDTH, 2);
      add_random_frame(MAX_ROWS, 2, 0);
      wait_idle();
      random_items = 0;

      // Random small frames, with the odd frame broken off partway.
      while (random_items < RANDOM_ITEMS) begin
         h = $urandom_range(1, 6);
         w = $urandom_range(1, 6);
         write_reg(REG_IMAGE_HEIGHT, h);
         write_reg(REG_IMAGE_WIDTH, w);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0)
               add_random_frame(h, w, $urandom_range(1, w * h + h));
            else
               add_random_frame(h, w, 0);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
